/* sv/gsst_pkg.sv */
// ----------------------------------------------------------------------------
// gsst_pkg
// shared constants and codes for the generational sparse set table
// ----------------------------------------------------------------------------
package gsst_pkg;

    localparam int ID_BITS   = 10;
    localparam int ID_DEPTH  = 1 << ID_BITS;
    localparam int SLOTS     = 256;
    localparam int SLOT_BITS = 8;
    localparam int GEN_BITS  = 16;
    localparam int CNT_BITS  = 9;
    localparam int MAP_W     = SLOT_BITS + 1;
    localparam int CLR_BITS  = ID_BITS + 1;

    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_LOOKUP = 3'd2;
    localparam logic [2:0] ACT_LOOKG  = 3'd3;
    localparam logic [2:0] ACT_RESET  = 3'd4;
    localparam logic [2:0] ACT_SHOW   = 3'd5;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_INUSE = 3'd2;
    localparam logic [2:0] ST_MISS  = 3'd3;
    localparam logic [2:0] ST_STALE = 3'd4;

    localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(SLOTS);

endpackage

/* sv/gsst_ram.sv */
// ----------------------------------------------------------------------------
// gsst_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/generational_sparse_set_table_top.sv */
// ----------------------------------------------------------------------------
// generational_sparse_set_table_top
// handle table mapping sparse ids to packed slots with generation counts
// ----------------------------------------------------------------------------
// steps: create reads the id map and the generation store, then writes;
//   lookups read the id map, then the generation store; remove reads the map,
//   moves the last slot into the hole, then unmaps; reset unmaps each active slot
// throughput: one word at a time, next word taken once the result is taken
// reset and every capacity write start a clearing pass of the id map and
//   generation store; no input word is taken during it
module generational_sparse_set_table_top
    import gsst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           action,
    input  logic [ID_BITS-1:0]   object_id,
    input  logic [GEN_BITS-1:0]  lookup_generation,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [ID_BITS-1:0]   result_id,
    output logic [SLOT_BITS-1:0] slot_index,
    output logic [GEN_BITS-1:0]  slot_generation,
    output logic [CNT_BITS-1:0]  active_count,
    output logic [CNT_BITS-1:0]  visible_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_BITS-1:0]  cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_RM1  = 4'd2;
    localparam logic [3:0] S_RM2  = 4'd3;
    localparam logic [3:0] S_RM3  = 4'd4;
    localparam logic [3:0] S_RM4  = 4'd5;
    localparam logic [3:0] S_LK1  = 4'd6;
    localparam logic [3:0] S_LK2  = 4'd7;
    localparam logic [3:0] S_RS   = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [CLR_BITS-1:0]  clr_reg, clr_next;
    logic [CNT_BITS-1:0]  cap_reg, cap_next;
    logic [CNT_BITS-1:0]  act_reg, act_next;
    logic [CNT_BITS-1:0]  vis_reg, vis_next;
    logic [ID_BITS-1:0]   nid_reg, nid_next;
    logic                 ov_reg, ov_next;
    logic [2:0]           op_reg, op_next;
    logic [ID_BITS-1:0]   oid_reg, oid_next;
    logic [GEN_BITS-1:0]  want_reg, want_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [GEN_BITS-1:0]  g0_reg, g0_next;
    logic [ID_BITS-1:0]   own_reg, own_next;
    logic [CNT_BITS-1:0]  walk_reg, walk_next;

    logic [2:0]           st_reg;
    logic [ID_BITS-1:0]   rid_reg;
    logic [SLOT_BITS-1:0] sl_reg;
    logic [GEN_BITS-1:0]  gn_reg;
    logic [CNT_BITS-1:0]  ac_reg, vc_reg;

    logic                 emit;
    logic [2:0]           e_st;
    logic [ID_BITS-1:0]   e_id;
    logic [SLOT_BITS-1:0] e_slot;
    logic [GEN_BITS-1:0]  e_gen;

    logic                 clearing, accept, full;
    logic [CNT_BITS-1:0]  usable, last;

    logic                 map_we, gen_we, own_we;
    logic [ID_BITS-1:0]   map_wa, map_ra;
    logic [MAP_W-1:0]     map_wd, map_q;
    logic [SLOT_BITS-1:0] gen_wa, gen_ra, own_wa, own_ra;
    logic [GEN_BITS-1:0]  gen_wd, gen_q;
    logic [ID_BITS-1:0]   own_wd, own_q;

    gsst_ram #(.WIDTH(MAP_W), .DEPTH(ID_DEPTH)) u_map (
        .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
        .raddr(map_ra), .rdata(map_q)
    );

    gsst_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen (
        .clk(clk), .we(gen_we), .waddr(gen_wa), .wdata(gen_wd),
        .raddr(gen_ra), .rdata(gen_q)
    );

    gsst_ram #(.WIDTH(ID_BITS), .DEPTH(SLOTS)) u_own (
        .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
        .raddr(own_ra), .rdata(own_q)
    );

    assign clearing  = (clr_reg != CLR_BITS'(ID_DEPTH));
    assign in_stall  = (state_reg != S_IDLE) | clearing | ov_reg;
    assign accept    = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign usable    = (cap_reg > CNT_BITS'(SLOTS)) ? CNT_BITS'(SLOTS) : cap_reg;
    assign full      = (act_reg >= usable);
    assign last      = act_reg - CNT_BITS'(1);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clearing ? clr_reg + CLR_BITS'(1) : clr_reg;
        cap_next   = cap_reg;
        act_next   = act_reg;
        vis_next   = vis_reg;
        nid_next   = nid_reg;
        op_next    = op_reg;
        oid_next   = oid_reg;
        want_next  = want_reg;
        slot_next  = slot_reg;
        g0_next    = g0_reg;
        own_next   = own_reg;
        walk_next  = walk_reg;
        emit       = 1'b0;
        e_st       = ST_OK;
        e_id       = oid_reg;
        e_slot     = '0;
        e_gen      = '0;
        map_we     = 1'b0;
        map_wa     = '0;
        map_wd     = '0;
        map_ra     = '0;
        gen_we     = 1'b0;
        gen_wa     = '0;
        gen_wd     = '0;
        gen_ra     = '0;
        own_we     = 1'b0;
        own_wa     = '0;
        own_wd     = '0;
        own_ra     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = action;
                    oid_next  = object_id;
                    want_next = lookup_generation;
                    e_id      = object_id;
                    unique case (action)
                        ACT_CREATE:
                        begin
                            nid_next = nid_reg + ID_BITS'(1);
                            oid_next = nid_reg;
                            e_id     = nid_reg;
                            if (full)
                            begin
                                emit = 1'b1;
                                e_st = ST_FULL;
                            end
                            else
                            begin
                                map_ra     = nid_reg;
                                gen_ra     = act_reg[SLOT_BITS-1:0];
                                slot_next  = act_reg[SLOT_BITS-1:0];
                                state_next = S_CR;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            map_ra     = object_id;
                            state_next = S_RM1;
                        end
                        ACT_LOOKUP, ACT_LOOKG:
                        begin
                            map_ra     = object_id;
                            state_next = S_LK1;
                        end
                        ACT_RESET:
                        begin
                            nid_next = '0;
                            if (act_reg == '0)
                            begin
                                vis_next = '0;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                own_ra     = '0;
                                walk_next  = '0;
                                state_next = S_RS;
                            end
                        end
                        ACT_SHOW:
                        begin
                            vis_next = act_reg;
                            emit     = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_CR:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                if (map_q[SLOT_BITS])
                begin
                    e_st = ST_INUSE;
                end
                else
                begin
                    map_we   = 1'b1;
                    map_wa   = oid_reg;
                    map_wd   = {1'b1, slot_reg};
                    gen_we   = 1'b1;
                    gen_wa   = slot_reg;
                    gen_wd   = gen_q + GEN_BITS'(1);
                    own_we   = 1'b1;
                    own_wa   = slot_reg;
                    own_wd   = oid_reg;
                    act_next = act_reg + CNT_BITS'(1);
                    vis_next = vis_reg + CNT_BITS'(1);
                    e_slot   = slot_reg;
                    e_gen    = gen_q + GEN_BITS'(1);
                end
            end
            S_RM1:
            begin
                if (!map_q[SLOT_BITS] || act_reg == '0)
                begin
                    emit       = 1'b1;
                    e_st       = ST_MISS;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = map_q[SLOT_BITS-1:0];
                    gen_ra     = map_q[SLOT_BITS-1:0];
                    own_ra     = last[SLOT_BITS-1:0];
                    state_next = S_RM2;
                end
            end
            S_RM2:
            begin
                g0_next    = gen_q;
                own_next   = own_q;
                gen_ra     = last[SLOT_BITS-1:0];
                state_next = S_RM3;
            end
            S_RM3:
            begin
                // last slot moves into the hole
                gen_we     = 1'b1;
                gen_wa     = slot_reg;
                gen_wd     = gen_q;
                own_we     = 1'b1;
                own_wa     = slot_reg;
                own_wd     = own_reg;
                map_we     = 1'b1;
                map_wa     = own_reg;
                map_wd     = {1'b1, slot_reg};
                state_next = S_RM4;
            end
            S_RM4:
            begin
                // unmap after the mover so removing the last slot ends unmapped
                map_we     = 1'b1;
                map_wa     = oid_reg;
                map_wd     = '0;
                act_next   = last;
                vis_next   = (vis_reg == '0) ? '0 : vis_reg - CNT_BITS'(1);
                emit       = 1'b1;
                e_slot     = slot_reg;
                e_gen      = g0_reg;
                state_next = S_IDLE;
            end
            S_LK1:
            begin
                if (!map_q[SLOT_BITS])
                begin
                    emit       = 1'b1;
                    e_st       = ST_MISS;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = map_q[SLOT_BITS-1:0];
                    gen_ra     = map_q[SLOT_BITS-1:0];
                    state_next = S_LK2;
                end
            end
            S_LK2:
            begin
                emit       = 1'b1;
                e_slot     = slot_reg;
                e_gen      = gen_q;
                state_next = S_IDLE;
                if (op_reg == ACT_LOOKG && gen_q != want_reg)
                begin
                    e_st = ST_STALE;
                end
            end
            S_RS:
            begin
                // owner read of the next slot overlaps the unmap of this one
                map_we    = 1'b1;
                map_wa    = own_q;
                map_wd    = '0;
                walk_next = walk_reg + CNT_BITS'(1);
                own_ra    = walk_next[SLOT_BITS-1:0];
                if (walk_next == act_reg)
                begin
                    act_next   = '0;
                    vis_next   = '0;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clearing)
        begin
            map_we = 1'b1;
            map_wa = clr_reg[ID_BITS-1:0];
            map_wd = '0;
            gen_we = (clr_reg < CLR_BITS'(SLOTS));
            gen_wa = clr_reg[SLOT_BITS-1:0];
            gen_wd = '0;
        end

        if (cfg_valid)
        begin
            cap_next = cfg_data;
            act_next = '0;
            vis_next = '0;
            clr_next = '0;
        end

        ov_next = emit | (ov_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            clr_reg   <= '0;
            cap_reg   <= CAP_RESET;
            act_reg   <= '0;
            vis_reg   <= '0;
            nid_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cap_reg   <= cap_next;
            act_reg   <= act_next;
            vis_reg   <= vis_next;
            nid_reg   <= nid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        oid_reg  <= oid_next;
        want_reg <= want_next;
        slot_reg <= slot_next;
        g0_reg   <= g0_next;
        own_reg  <= own_next;
        walk_reg <= walk_next;
        if (emit)
        begin
            st_reg  <= e_st;
            rid_reg <= e_id;
            sl_reg  <= e_slot;
            gn_reg  <= e_gen;
            ac_reg  <= act_next;
            vc_reg  <= vis_next;
        end
    end

    assign out_valid       = ov_reg;
    assign status          = st_reg;
    assign result_id       = rid_reg;
    assign slot_index      = sl_reg;
    assign slot_generation = gn_reg;
    assign active_count    = ac_reg;
    assign visible_count   = vc_reg;

endmodule

/* sv/gsst_checker.sv */
// ----------------------------------------------------------------------------
// gsst_checker
// port level checks on the result word of the handle table
// ----------------------------------------------------------------------------
module gsst_checker
    import gsst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [2:0]           status,
    input logic [SLOT_BITS-1:0] slot_index,
    input logic [GEN_BITS-1:0]  slot_generation,
    input logic [CNT_BITS-1:0]  active_count,
    input logic [CNT_BITS-1:0]  visible_count
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result word dropped while stalled");

    a_vis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> visible_count <= active_count)
        else $error("visible count above active count");

    a_act: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> active_count <= CNT_BITS'(SLOTS))
        else $error("active count above slot store");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MISS || status == ST_FULL || status == ST_INUSE)
        |-> slot_index == '0 && slot_generation == '0)
        else $error("slot fields set on a failed word");

endmodule

bind generational_sparse_set_table_top gsst_checker u_gsst_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational sparse set table testbench
// directed and random handle table traffic checked against a behavioural
// copy of the table: ids, slots, generations, counts, capacity changes
// ----------------------------------------------------------------------------
module testbench;
    import gsst_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [2:0]           st;
        logic [ID_BITS-1:0]   id;
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
        logic [CNT_BITS-1:0]  act;
        logic [CNT_BITS-1:0]  vis;
    } table_reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           action;
    logic [ID_BITS-1:0]   object_id;
    logic [GEN_BITS-1:0]  lookup_generation;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           status;
    logic [ID_BITS-1:0]   result_id;
    logic [SLOT_BITS-1:0] slot_index;
    logic [GEN_BITS-1:0]  slot_generation;
    logic [CNT_BITS-1:0]  active_count;
    logic [CNT_BITS-1:0]  visible_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_BITS-1:0]  cfg_data;

    // shadow of the table
    bit                   id_mapped [ID_DEPTH];
    logic [SLOT_BITS:0]   id_slot   [ID_DEPTH];
    logic [ID_BITS-1:0]   slot_owner[SLOTS];
    logic [GEN_BITS-1:0]  slot_gen  [SLOTS];
    logic [ID_BITS-1:0]   next_id;
    int unsigned          active_total;
    int unsigned          visible_total;
    int unsigned          capacity;

    table_reply_t         pending_replies[$];
    int                   errors;
    int                   words_sent;
    int                   replies_checked;
    int                   cfg_writes;
    int unsigned          cycles;
    int                   hold_cycles;
    int                   rx_pause;
    int                   stall_pct;
    int                   gap_pct;

    generational_sparse_set_table_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .object_id(object_id), .lookup_generation(lookup_generation),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_id(result_id), .slot_index(slot_index),
        .slot_generation(slot_generation), .active_count(active_count),
        .visible_count(visible_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure, with a long hold on request and the odd long pause
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_pause  <= 0;
        end
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (rx_pause > 0)
        begin
            out_stall <= 1'b1;
            rx_pause  <= rx_pause - 1;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            out_stall <= 1'b1;
            rx_pause  <= $urandom_range(10, 40);
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // outputs are stable at the falling edge, so the word is taken at the next rise
    always @(negedge clk)
    begin
        table_reply_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
                report("unexpected word, status", status, -1);
            else
            begin
                exp_r = pending_replies.pop_front();
                replies_checked++;
                if (status != exp_r.st)            report("status", status, exp_r.st);
                if (result_id != exp_r.id)         report("result_id", result_id, exp_r.id);
                if (slot_index != exp_r.slot)      report("slot_index", slot_index, exp_r.slot);
                if (slot_generation != exp_r.gen)  report("slot_generation", slot_generation,
                                                          exp_r.gen);
                if (active_count != exp_r.act)     report("active_count", active_count, exp_r.act);
                if (visible_count != exp_r.vis)    report("visible_count", visible_count,
                                                          exp_r.vis);
            end
        end
    end

    task automatic clear_table();
        for (int i = 0; i < ID_DEPTH; i++)
        begin
            id_mapped[i] = 1'b0;
            id_slot[i]   = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_owner[i] = '0;
            slot_gen[i]   = '0;
        end
        active_total  = 0;
        visible_total = 0;
    endtask

    task automatic push_reply(input logic [2:0] st, input logic [ID_BITS-1:0] id,
                              input int slot, input logic [GEN_BITS-1:0] gen);
        table_reply_t r;
        r.st   = st;
        r.id   = id;
        r.slot = SLOT_BITS'(slot);
        r.gen  = gen;
        r.act  = CNT_BITS'(active_total);
        r.vis  = CNT_BITS'(visible_total);
        pending_replies.push_back(r);
    endtask

    task automatic table_step(input logic [2:0] act, input logic [ID_BITS-1:0] oid,
                              input logic [GEN_BITS-1:0] want);
        logic [ID_BITS-1:0]  id;
        int                  slot;
        int                  usable;
        logic [GEN_BITS-1:0] gen;
        logic [ID_BITS-1:0]  mover;
        usable = (capacity > SLOTS) ? SLOTS : capacity;
        case (act)
            ACT_CREATE:
            begin
                id      = next_id;
                next_id = next_id + 1'b1;
                if (active_total >= usable)
                    push_reply(ST_FULL, id, 0, '0);
                else if (id_mapped[id])
                    push_reply(ST_INUSE, id, 0, '0);
                else
                begin
                    slot             = active_total;
                    slot_owner[slot] = id;
                    slot_gen[slot]   = slot_gen[slot] + 1'b1;
                    id_mapped[id]    = 1'b1;
                    id_slot[id]      = (SLOT_BITS+1)'(slot);
                    active_total++;
                    visible_total++;
                    push_reply(ST_OK, id, slot, slot_gen[slot]);
                end
            end
            ACT_REMOVE:
            begin
                slot = int'(id_slot[oid]);
                if (!id_mapped[oid] || slot >= SLOTS || active_total == 0)
                    push_reply(ST_MISS, oid, 0, '0);
                else
                begin
                    gen = slot_gen[slot];
                    active_total--;
                    if (visible_total > 0)
                        visible_total--;
                    // last slot fills the hole
                    slot_gen[slot]   = slot_gen[active_total];
                    slot_owner[slot] = slot_owner[active_total];
                    mover            = slot_owner[slot];
                    id_slot[mover]   = (SLOT_BITS+1)'(slot);
                    id_mapped[mover] = 1'b1;
                    id_mapped[oid]   = 1'b0;
                    push_reply(ST_OK, oid, slot, gen);
                end
            end
            ACT_LOOKUP, ACT_LOOKG:
            begin
                slot = int'(id_slot[oid]);
                if (!id_mapped[oid] || slot >= SLOTS)
                    push_reply(ST_MISS, oid, 0, '0);
                else if (act == ACT_LOOKG && slot_gen[slot] != want)
                    push_reply(ST_STALE, oid, slot, slot_gen[slot]);
                else
                    push_reply(ST_OK, oid, slot, slot_gen[slot]);
            end
            ACT_RESET:
            begin
                for (int i = 0; i < active_total && i < SLOTS; i++)
                    id_mapped[slot_owner[i]] = 1'b0;
                active_total  = 0;
                visible_total = 0;
                next_id       = '0;
                push_reply(ST_OK, oid, 0, '0);
            end
            ACT_SHOW:
            begin
                visible_total = active_total;
                push_reply(ST_OK, oid, 0, '0);
            end
            default:
                push_reply(ST_OK, oid, 0, '0);
        endcase
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_word(input logic [2:0] act, input logic [ID_BITS-1:0] oid,
                             input logic [GEN_BITS-1:0] want);
        int gap;
        in_valid          <= 1'b1;
        action            <= act;
        object_id         <= oid;
        lookup_generation <= want;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        table_step(act, oid, want);
        words_sent++;
        if ($urandom_range(0, 99) < gap_pct)
            gap = ($urandom_range(0, 99) < 5) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        else
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_BITS-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        capacity = value;
        clear_table();
        cfg_writes++;
    endtask

    function automatic logic [ID_BITS-1:0] live_id();
        if (active_total == 0 || $urandom_range(0, 99) < 15)
            return ID_BITS'($urandom());
        return slot_owner[$urandom_range(0, active_total - 1)];
    endfunction

    task automatic random_word();
        int                  pick;
        logic [ID_BITS-1:0]  oid;
        logic [GEN_BITS-1:0] want;
        pick = $urandom_range(0, 99);
        oid  = live_id();
        want = ($urandom_range(0, 99) < 60 && id_slot[oid] < SLOTS) ?
               slot_gen[id_slot[oid]] : GEN_BITS'($urandom());
        if (pick < 38)       send_word(ACT_CREATE, ID_BITS'($urandom()), GEN_BITS'($urandom()));
        else if (pick < 58)  send_word(ACT_REMOVE, oid, GEN_BITS'($urandom()));
        else if (pick < 74)  send_word(ACT_LOOKUP, oid, GEN_BITS'($urandom()));
        else if (pick < 90)  send_word(ACT_LOOKG, oid, want);
        else if (pick < 92)  send_word(ACT_RESET, ID_BITS'($urandom()), GEN_BITS'($urandom()));
        else if (pick < 97)  send_word(ACT_SHOW, ID_BITS'($urandom()), GEN_BITS'($urandom()));
        else                 send_word(pick[0] ? ACT_SPARE_HI : ACT_SPARE_LO,
                                       ID_BITS'($urandom()), GEN_BITS'($urandom()));
    endtask

    task automatic test_directed();
        write_capacity(CAP_RESET);
        send_word(ACT_LOOKUP, 10'd0, 16'h0000);
        send_word(ACT_REMOVE, 10'd1023, 16'h0000);
        repeat (4) send_word(ACT_CREATE, 10'd0, 16'h0000);
        send_word(ACT_LOOKUP, 10'd2, 16'h0000);
        send_word(ACT_LOOKG, 10'd2, 16'h0001);
        send_word(ACT_LOOKG, 10'd2, 16'hffff);
        send_word(ACT_REMOVE, 10'd1, 16'h0000);   // hole refilled from the last slot
        send_word(ACT_LOOKUP, 10'd3, 16'h0000);
        send_word(ACT_REMOVE, 10'd1, 16'h0000);
        send_word(ACT_SHOW, 10'd1023, 16'hffff);
        send_word(ACT_SPARE_LO, 10'd1023, 16'hffff);
        send_word(ACT_SPARE_HI, 10'd0, 16'h0000);
        send_word(ACT_RESET, 10'd512, 16'h8000);
        send_word(ACT_LOOKUP, 10'd0, 16'h0000);
        send_word(ACT_CREATE, 10'd0, 16'h0000);
        write_capacity(9'd0);                     // always full
        send_word(ACT_CREATE, 10'd0, 16'h0000);
        write_capacity(9'd1);
        repeat (2) send_word(ACT_CREATE, 10'd0, 16'h0000);
        send_word(ACT_REMOVE, 10'd0, 16'h0000);   // id 0 no longer mapped, so a miss
        send_word(ACT_CREATE, 10'd0, 16'h0000);
    endtask

    // wrap the running id round onto one that is still held
    task automatic test_id_in_use();
        gap_pct   = 0;
        stall_pct = 0;
        write_capacity(9'd2);
        // running id back to zero so ids 0 and 1 take the two slots
        send_word(ACT_RESET, 10'd0, 16'h0000);
        for (int i = 0; i < ID_DEPTH; i++)
            send_word(ACT_CREATE, 10'd0, 16'h0000);
        send_word(ACT_REMOVE, 10'd1, 16'h0000);
        send_word(ACT_CREATE, 10'd0, 16'h0000);
    endtask

    task automatic test_back_pressure();
        write_capacity(CAP_RESET);
        gap_pct     = 0;
        hold_cycles = 300;
        repeat (12) send_word(ACT_CREATE, 10'd0, 16'h0000);
        wait_drained();
        for (int i = 0; i < 8; i++)
            send_word(ACT_LOOKG, live_id(), GEN_BITS'($urandom()));
    endtask

    task automatic test_random();
        logic [CNT_BITS-1:0] caps[6];
        caps = '{CAP_RESET, 9'd8, 9'd1, 9'h1ff, 9'd2, 9'd0};
        caps[4] = CNT_BITS'($urandom_range(1, 300));
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            gap_pct   = (p % 3 == 1) ? 0 : $urandom_range(10, 60);
            repeat (p == 5 ? 20 : 32) random_word();
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        action            = ACT_CREATE;
        object_id         = '0;
        lookup_generation = '0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        out_stall         = 1'b0;
        cycles            = 0;
        hold_cycles       = 0;
        stall_pct         = 20;
        gap_pct           = 20;
        errors            = 0;
        words_sent        = 0;
        replies_checked   = 0;
        cfg_writes        = 0;
        capacity          = CAP_RESET;
        next_id           = '0;
        clear_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_id_in_use();
        test_back_pressure();
        test_random();

        wait_drained();
        repeat (300) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d capacity writes, %0d errors",
                 words_sent, replies_checked, cfg_writes, errors);
        $display("covered create, remove, both lookups, reset, show all and spare actions");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
sv/gsst_pkg.sv
sv/gsst_ram.sv
sv/generational_sparse_set_table_top.sv
sv/gsst_checker.sv
tb/testbench.sv
